// File: sv/assert_macros.svh
// Assertion macros used by the checker module of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RSHD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rshd assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define RSHD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("rshd assertion failed");

`endif

// File: sv/rshd_pkg.sv
// Shared types and width constants for the ray/segment hit distance block.
// No dependencies.
`timescale 1ns / 1ps

package rshd_pkg;

    localparam int COORD_W = 32;        // input coordinate width
    localparam int DIFF_W  = 33;        // coordinate difference width
    localparam int PROD_W  = 66;        // one cross-product term
    localparam int WIDE_W  = 67;        // difference of two product terms
    localparam int MAG_W   = 66;        // magnitude of a wide value
    localparam int ROOT_W  = 33;        // ray length, integer square root
    localparam int DIST_W  = 32;        // distance output
    localparam int NUM_W   = 99;        // magnitude of u numerator times length
    localparam int CHUNK_W = 22;        // slice of the numerator per multiplier
    localparam int PART_W  = CHUNK_W + ROOT_W;

    // Per-item data that rides along the square root pipeline.
    typedef struct packed {
        logic             hit;
        logic [MAG_W-1:0] aden;
        logic [MAG_W-1:0] mu;
    } t_side;

endpackage

// File: sv/ray_segment_hit_distance.sv
// Ray / edge-segment hit distance. One item enters per clock while the skid
// register is empty; each item passes 5 front stages, 33 square root stages,
// 3 scaling stages, 32 divider stages and the output register. The result stage
// has a skid register, so the pipeline keeps taking items while one result waits.
// Depends on rshd_pkg, rshd_front, rshd_sqrt and rshd_div.
`timescale 1ns / 1ps

module ray_segment_hit_distance #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_edge_start_x,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_edge_start_y,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_edge_end_x,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_edge_end_y,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_ray_origin_x,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_ray_origin_y,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_ray_target_x,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_ray_target_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [rshd_pkg::DIST_W-1:0]       o_hit_distance
);

    logic                        w_en;
    logic                        w_f_vld, w_s_vld, w_d_vld, w_d_hit;
    logic [rshd_pkg::MAG_W-1:0]  w_lsq;
    logic [rshd_pkg::ROOT_W-1:0] w_len;
    logic [rshd_pkg::DIST_W-1:0] w_d_dist;
    rshd_pkg::t_side             w_f_side, w_s_side;

    logic                        r_out_vld, r_skid_vld, r_out_hit, r_skid_hit;
    logic [rshd_pkg::DIST_W-1:0] r_out_dist, r_skid_dist;
    logic                        w_take;

    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;
    assign w_take     = r_out_vld && i_out_ready;

    rshd_front #(.FRAC_BITS(COORD_FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_e0x   (i_edge_start_x),
        .i_e0y   (i_edge_start_y),
        .i_e1x   (i_edge_end_x),
        .i_e1y   (i_edge_end_y),
        .i_ax    (i_ray_origin_x),
        .i_ay    (i_ray_origin_y),
        .i_bx    (i_ray_target_x),
        .i_by    (i_ray_target_y),
        .o_vld   (w_f_vld),
        .o_lsq   (w_lsq),
        .o_side  (w_f_side)
    );

    rshd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_lsq   (w_lsq),
        .i_side  (w_f_side),
        .o_vld   (w_s_vld),
        .o_len   (w_len),
        .o_side  (w_s_side)
    );

    rshd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_len   (w_len),
        .i_side  (w_s_side),
        .o_vld   (w_d_vld),
        .o_hit   (w_d_hit),
        .o_dist  (w_d_dist)
    );

    // Output register plus skid register; the pipeline stalls only while the
    // skid register holds an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_d_vld) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_hit  <= r_skid_hit;
                r_out_dist <= r_skid_dist;
            end
        end else if (w_d_vld) begin
            if (!r_out_vld || w_take) begin
                r_out_hit  <= w_d_hit;
                r_out_dist <= w_d_dist;
            end else begin
                r_skid_hit  <= w_d_hit;
                r_skid_dist <= w_d_dist;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_hit          = r_out_hit;
    assign o_hit_distance = r_out_dist;

endmodule

// File: sv/rshd_front.sv
// Front pipeline: differences, cross products, denominator and hit decision.
// Depends on rshd_pkg.
`timescale 1ns / 1ps

module rshd_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_e0x,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_e0y,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_e1x,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_e1y,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_ax,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_ay,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_bx,
    input  logic signed [rshd_pkg::COORD_W-1:0] i_by,
    output logic                              o_vld,
    output logic [rshd_pkg::MAG_W-1:0]        o_lsq,
    output rshd_pkg::t_side                   o_side
);

    localparam int ThrShift = 2 * FRAC_BITS - 23;
    localparam logic [rshd_pkg::MAG_W-1:0] Thr =
        (ThrShift >= 0) ? (rshd_pkg::MAG_W'(1) << ThrShift) : '0;

    logic [5:1] r_vld;

    logic signed [rshd_pkg::DIFF_W-1:0] r1_dx, r1_dy, r1_ex, r1_ey, r1_rx, r1_ry;
    logic signed [rshd_pkg::PROD_W-1:0] r2_dyex, r2_dxey, r2_rydx, r2_rxdy;
    logic signed [rshd_pkg::PROD_W-1:0] r2_ryex, r2_rxey, r2_dxx, r2_dyy;
    logic signed [rshd_pkg::WIDE_W-1:0] r3_den, r3_nt, r3_nu;
    logic [rshd_pkg::MAG_W-1:0]         r3_lsq, r4_lsq, r5_lsq;
    logic [rshd_pkg::MAG_W-1:0]         r4_aden, r4_mt, r4_mu;
    logic                               r4_dneg, r4_tneg, r4_uneg, r4_tzero, r4_uzero;
    rshd_pkg::t_side                    r5_side;

    logic n5_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:1], i_vld};
        end
    end

    always_comb begin
        n5_hit = (r4_aden > Thr)
              && (r4_tzero || ((r4_tneg == r4_dneg) && (r4_mt <= r4_aden)))
              && !r4_uzero && (r4_uneg == r4_dneg) && (r4_mu >= r4_aden);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= {i_bx[31], i_bx} - {i_ax[31], i_ax};
            r1_dy <= {i_by[31], i_by} - {i_ay[31], i_ay};
            r1_ex <= {i_e1x[31], i_e1x} - {i_e0x[31], i_e0x};
            r1_ey <= {i_e1y[31], i_e1y} - {i_e0y[31], i_e0y};
            r1_rx <= {i_e0x[31], i_e0x} - {i_ax[31], i_ax};
            r1_ry <= {i_e0y[31], i_e0y} - {i_ay[31], i_ay};

            r2_dyex <= r1_dy * r1_ex;
            r2_dxey <= r1_dx * r1_ey;
            r2_rydx <= r1_ry * r1_dx;
            r2_rxdy <= r1_rx * r1_dy;
            r2_ryex <= r1_ry * r1_ex;
            r2_rxey <= r1_rx * r1_ey;
            r2_dxx  <= r1_dx * r1_dx;
            r2_dyy  <= r1_dy * r1_dy;

            r3_den <= {r2_dyex[65], r2_dyex} - {r2_dxey[65], r2_dxey};
            r3_nt  <= {r2_rydx[65], r2_rydx} - {r2_rxdy[65], r2_rxdy};
            r3_nu  <= {r2_ryex[65], r2_ryex} - {r2_rxey[65], r2_rxey};
            // Both squares are non-negative and below 2^65 together.
            r3_lsq <= r2_dxx[65:0] + r2_dyy[65:0];

            r4_dneg  <= r3_den[66];
            r4_tneg  <= r3_nt[66];
            r4_uneg  <= r3_nu[66];
            r4_tzero <= (r3_nt == '0);
            r4_uzero <= (r3_nu == '0);
            r4_aden  <= r3_den[66] ? (~r3_den[65:0] + 66'd1) : r3_den[65:0];
            r4_mt    <= r3_nt[66]  ? (~r3_nt[65:0]  + 66'd1) : r3_nt[65:0];
            r4_mu    <= r3_nu[66]  ? (~r3_nu[65:0]  + 66'd1) : r3_nu[65:0];
            r4_lsq   <= r3_lsq;

            r5_side.hit  <= n5_hit;
            r5_side.aden <= r4_aden;
            r5_side.mu   <= r4_mu;
            r5_lsq       <= r4_lsq;
        end
    end

    assign o_vld  = r_vld[5];
    assign o_lsq  = r5_lsq;
    assign o_side = r5_side;

endmodule

// File: sv/rshd_sqrt.sv
// Integer square root of the squared ray length, one result bit per stage.
// Depends on rshd_pkg.
`timescale 1ns / 1ps

module rshd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [rshd_pkg::MAG_W-1:0]  i_lsq,
    input  rshd_pkg::t_side             i_side,
    output logic                        o_vld,
    output logic [rshd_pkg::ROOT_W-1:0] o_len,
    output rshd_pkg::t_side             o_side
);

    localparam int Stages = rshd_pkg::ROOT_W;

    logic                        r_vld  [1:Stages];
    logic [rshd_pkg::MAG_W-1:0]  r_rem  [1:Stages];
    logic [rshd_pkg::ROOT_W-1:0] r_root [1:Stages];
    rshd_pkg::t_side             r_side [1:Stages];

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        localparam int Bit = Stages - 1 - k;

        logic                        s_vld;
        logic [rshd_pkg::MAG_W-1:0]  s_rem;
        logic [rshd_pkg::ROOT_W-1:0] s_root;
        rshd_pkg::t_side             s_side;
        logic [67:0]                 s_trial;
        logic                        s_ge;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = i_lsq;
            assign s_root = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[k];
            assign s_rem  = r_rem[k];
            assign s_root = r_root[k];
            assign s_side = r_side[k];
        end

        // Setting this bit adds 2^(Bit+1)*root + 2^(2*Bit) to the square.
        assign s_trial = (68'(s_root) << (Bit + 1)) + (68'd1 << (2 * Bit));
        assign s_ge    = (68'(s_rem) >= s_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= s_side;
                if (s_ge) begin
                    r_rem[k+1]  <= s_rem - s_trial[rshd_pkg::MAG_W-1:0];
                    r_root[k+1] <= s_root | (rshd_pkg::ROOT_W'(1) << Bit);
                end else begin
                    r_rem[k+1]  <= s_rem;
                    r_root[k+1] <= s_root;
                end
            end
        end
    end

    assign o_vld  = r_vld[Stages];
    assign o_len  = r_root[Stages];
    assign o_side = r_side[Stages];

endmodule

// File: sv/rshd_div.sv
// Scales the u numerator by the ray length and divides by |den|, saturating.
// Depends on rshd_pkg.
`timescale 1ns / 1ps

module rshd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [rshd_pkg::ROOT_W-1:0] i_len,
    input  rshd_pkg::t_side             i_side,
    output logic                        o_vld,
    output logic                        o_hit,
    output logic [rshd_pkg::DIST_W-1:0] o_dist
);

    localparam int Stages = rshd_pkg::DIST_W;
    localparam int NW     = rshd_pkg::NUM_W;
    localparam int CW     = rshd_pkg::CHUNK_W;

    logic [3:1] r_pvld;
    logic [rshd_pkg::PART_W-1:0] r1_p0, r1_p1, r1_p2;
    logic [rshd_pkg::MAG_W-1:0]  r1_aden, r2_aden, r3_aden;
    logic                        r1_hit, r2_hit, r3_hit, r3_sat;
    logic [NW-1:0]               r2_prod, r3_prod;

    logic                        r_vld  [1:Stages];
    logic [NW-1:0]               r_rem  [1:Stages];
    logic [rshd_pkg::MAG_W-1:0]  r_aden [1:Stages];
    logic [Stages-1:0]           r_quo  [1:Stages];
    logic                        r_hit  [1:Stages];
    logic                        r_sat  [1:Stages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= '0;
        end else if (i_en) begin
            r_pvld <= {r_pvld[2:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p0   <= i_side.mu[CW-1:0] * i_len;
            r1_p1   <= i_side.mu[2*CW-1:CW] * i_len;
            r1_p2   <= i_side.mu[3*CW-1:2*CW] * i_len;
            r1_aden <= i_side.aden;
            r1_hit  <= i_side.hit;

            r2_prod <= NW'(r1_p0) + (NW'(r1_p1) << CW) + (NW'(r1_p2) << (2 * CW));
            r2_aden <= r1_aden;
            r2_hit  <= r1_hit;

            // The quotient overflows 32 bits exactly when prod >= aden * 2^32.
            r3_sat  <= (r2_prod >= (NW'(r2_aden) << Stages));
            r3_prod <= r2_prod;
            r3_aden <= r2_aden;
            r3_hit  <= r2_hit;
        end
    end

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        localparam int Bit = Stages - 1 - k;

        logic                       s_vld, s_hit, s_sat, s_ge;
        logic [NW-1:0]              s_rem, s_trial;
        logic [rshd_pkg::MAG_W-1:0] s_aden;
        logic [Stages-1:0]          s_quo;

        if (k == 0) begin : g_first
            assign s_vld  = r_pvld[3];
            assign s_rem  = r3_prod;
            assign s_aden = r3_aden;
            assign s_quo  = '0;
            assign s_hit  = r3_hit;
            assign s_sat  = r3_sat;
        end else begin : g_next
            assign s_vld  = r_vld[k];
            assign s_rem  = r_rem[k];
            assign s_aden = r_aden[k];
            assign s_quo  = r_quo[k];
            assign s_hit  = r_hit[k];
            assign s_sat  = r_sat[k];
        end

        assign s_trial = NW'(s_aden) << Bit;
        assign s_ge    = (s_rem >= s_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_aden[k+1] <= s_aden;
                r_hit[k+1]  <= s_hit;
                r_sat[k+1]  <= s_sat;
                if (s_ge) begin
                    r_rem[k+1] <= s_rem - s_trial;
                    r_quo[k+1] <= s_quo | (Stages'(1) << Bit);
                end else begin
                    r_rem[k+1] <= s_rem;
                    r_quo[k+1] <= s_quo;
                end
            end
        end
    end

    assign o_vld  = r_vld[Stages];
    assign o_hit  = r_hit[Stages];
    assign o_dist = !r_hit[Stages] ? '0 : (r_sat[Stages] ? '1 : r_quo[Stages]);

endmodule

// File: sv/rshd_checker.sv
// Port-level checks for ray_segment_hit_distance, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rshd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_hit,
    input logic [31:0] o_hit_distance
);

    // A miss always reports zero distance.
    `RSHD_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_out_valid && !o_hit) |-> (o_hit_distance == 32'd0))

    // A waiting result keeps its payload.
    `RSHD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_hit) && $stable(o_hit_distance)))

    // The input side only stalls while a result is waiting.
    `RSHD_ASSERT(a_ready_idle, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // Reset empties the output.
    `RSHD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind ray_segment_hit_distance rshd_checker u_rshd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_hit          (o_hit),
    .o_hit_distance (o_hit_distance)
);

// File: test/tb.sv
// Self-checking bench for ray_segment_hit_distance: random and directed
// ray/edge items, hit flag and distance checked against an in-bench predictor.
// Depends on ray_segment_hit_distance.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1650;
    localparam int LATENCY   = 80;

    typedef struct packed {
        logic signed [31:0] sx, sy, ex, ey, ox, oy, tx, ty;
    } seg_ray_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hdist;
    } hit_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] i_sx = '0, i_sy = '0, i_ex = '0, i_ey = '0;
    logic signed [31:0] i_ox = '0, i_oy = '0, i_tx = '0, i_ty = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_hit;
    logic [31:0] o_hit_distance;

    seg_ray_t pending_items[$];
    hit_t     expected_hits[$];
    int       n_errors = 0;
    bit       drain_req = 1'b0;
    int       send_wait = 0;
    int       recv_wait = 0;

    always #1 i_clk = ~i_clk;

    ray_segment_hit_distance #(.COORD_FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_edge_start_x(i_sx), .i_edge_start_y(i_sy),
        .i_edge_end_x(i_ex), .i_edge_end_y(i_ey),
        .i_ray_origin_x(i_ox), .i_ray_origin_y(i_oy),
        .i_ray_target_x(i_tx), .i_ray_target_y(i_ty),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_hit(o_hit), .o_hit_distance(o_hit_distance)
    );

    function automatic logic [63:0] isqrt(input logic [131:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({68'd0, c} * {68'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic hit_t predict_hit(input seg_ray_t it);
        logic signed [131:0] dx, dy, ex, ey, rx, ry, den, nt, nu;
        logic [131:0] aden, mt, mu, lsq, prod, q, thr;
        logic [63:0]  len;
        logic         dneg;
        hit_t         res;
        res = '0;
        dx = $signed(it.tx) - $signed(it.ox);
        dy = $signed(it.ty) - $signed(it.oy);
        ex = $signed(it.ex) - $signed(it.sx);
        ey = $signed(it.ey) - $signed(it.sy);
        rx = $signed(it.sx) - $signed(it.ox);
        ry = $signed(it.sy) - $signed(it.oy);
        thr = (2 * FRAC - 23 >= 0) ? (132'd1 << (2 * FRAC - 23)) : '0;
        den = dy * ex - dx * ey;
        aden = den < 0 ? -den : den;
        if (aden <= thr) return res;
        dneg = den < 0;
        nt = ry * dx - rx * dy;
        if (nt != 0) begin
            mt = nt < 0 ? -nt : nt;
            if ((nt < 0) != dneg) return res;
            if (mt > aden) return res;
        end
        nu = ry * ex - rx * ey;
        if (nu == 0 || (nu < 0) != dneg) return res;
        mu = nu < 0 ? -nu : nu;
        if (mu < aden) return res;
        lsq = dx * dx + dy * dy;
        len = isqrt(lsq);
        prod = mu * len;
        q = prod / aden;
        res.hit = 1'b1;
        res.hdist = (q > 132'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        return res;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
        endcase
    endfunction

    // Build an edge that straddles a point past the target, so most items hit.
    function automatic seg_ray_t likely_hit();
        seg_ray_t it;
        int   span;
        logic signed [31:0] px, py, nx, ny;
        span = $urandom_range(0, 2) == 0 ? 32'h0FFF_FFFF : 32'h003F_FFFF;
        it.ox = $signed($urandom_range(0, span)) - span / 2;
        it.oy = $signed($urandom_range(0, span)) - span / 2;
        it.tx = it.ox + ($signed($urandom_range(0, span)) - span / 2);
        it.ty = it.oy + ($signed($urandom_range(0, span)) - span / 2);
        px = it.tx + ((it.tx - it.ox) >>> $urandom_range(0, 3));
        py = it.ty + ((it.ty - it.oy) >>> $urandom_range(0, 3));
        nx = $signed($urandom_range(0, span)) - span / 2;
        ny = $signed($urandom_range(0, span)) - span / 2;
        it.sx = px + nx;
        it.sy = py + ny;
        it.ex = px - nx;
        it.ey = py - ny;
        return it;
    endfunction

    task automatic queue_item(input seg_ray_t it);
        pending_items.push_back(it);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0h expected %0h", what, got, want);
        n_errors++;
    endtask

    // Driver: each item waits a random gap before valid rises.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_ready) begin
        end else if (i_in_valid && o_in_ready) begin
            expected_hits.push_back(predict_hit({i_sx, i_sy, i_ex, i_ey,
                                                 i_ox, i_oy, i_tx, i_ty}));
            send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (send_wait == 0 && pending_items.size() > 0 && !drain_req) begin
                {i_sx, i_sy, i_ex, i_ey, i_ox, i_oy, i_tx, i_ty} <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (send_wait > 0) begin
            send_wait--;
        end else if (pending_items.size() > 0 && !drain_req) begin
            {i_sx, i_sy, i_ex, i_ey, i_ox, i_oy, i_tx, i_ty} <= pending_items.pop_front();
            i_in_valid <= 1'b1;
        end
    end

    // Monitor: ready is dropped for random stretches, then each result is checked.
    always @(posedge i_clk) begin
        hit_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected item", o_hit_distance, 32'd0);
                end else begin
                    want = expected_hits.pop_front();
                    if (o_hit !== want.hit)
                        report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                    if (o_hit_distance !== want.hdist)
                        report_mismatch("hit_distance", o_hit_distance, want.hdist);
                end
                recv_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        seg_ray_t it;
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        // Plain crossing beyond the target, and one short of it.
        queue_item({32'sh0003_0000, -32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        queue_item({32'sh0000_8000, -32'sh0001_0000, 32'sh0000_8000, 32'sh0001_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        // Crossing exactly at the target, and at an edge endpoint.
        queue_item({32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        queue_item({32'sh0002_0000, 32'sh0, 32'sh0002_0000, 32'sh0001_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        // Edge behind the origin, edge missed, parallel edge, zero-length ray.
        queue_item({-32'sh0002_0000, -32'sh0001_0000, -32'sh0002_0000, 32'sh0001_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        queue_item({32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0003_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        queue_item({32'sh0, 32'sh0001_0000, 32'sh0005_0000, 32'sh0001_0000,
                    32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0});
        queue_item({32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                    32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000});
        // Short rays across an edge; den lies above the threshold in each of the three.
        queue_item({32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0,
                    32'sh0, 32'sh0, 32'sh0, 32'sh0200});
        queue_item({32'sh0, -32'sh0010_0000, 32'sh0001_0000, 32'sh0010_0000,
                    32'sh0, -32'sh0001_0000, 32'sh0, -32'sh0000_FF00});
        queue_item({32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0,
                    32'sh0, 32'sh0, 32'sh0, 32'sh0201});
        // Tiny ray, far edge: a large distance that stays below saturation.
        queue_item({mx, mn, mx, mx, 32'sh0, 32'sh0, 32'sh1, 32'sh0});
        // Extreme coordinates.
        queue_item({mn, mn, mx, mx, mx, mn, mn, mx});
        queue_item({mx, mn, mn, mx, mn, mn, 32'sh0, 32'sh0});
        queue_item({mn, mx, mn, mn, mx, mx, 32'sh0, 32'sh0});
        queue_item({mx, mx, mx, mn, mn, 32'sh0, 32'sh0, 32'sh0});
        queue_item({32'shFFFF_FFFF, mn, 32'shFFFF_FFFF, mx, mn, 32'sh0, mx, 32'sh0});
        queue_item({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
        queue_item({32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                    32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let the directed items drain fully before the random part starts.
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_hits.size() != 0);
        drain_req = 1'b1;
        @(negedge i_clk);
        drain_req = 1'b0;

        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                it = likely_hit();
            end else begin
                it = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            end
            queue_item(it);
        end

        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_hits.size() != 0);
        repeat (LATENCY) @(posedge i_clk);
        if (n_errors == 0 && expected_hits.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
